### design/wrsp_pkg.sv
package wrsp_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CHK,
		ST_PR_RD,
		ST_PR_CHK,
		ST_RF_MUL,
		ST_RF_CHK,
		ST_SC_RD,
		ST_SC_MUL,
		ST_SC_ACC,
		ST_LT_M1,
		ST_LT_M2,
		ST_LT_M3,
		ST_LT_CHK,
		ST_SR_MUL,
		ST_SR_LHS,
		ST_SR_RD,
		ST_SR_CHK,
		ST_OUT_RD,
		ST_OUT_CAP,
		ST_RM_RD,
		ST_RM_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] host;
		logic [15:0] weight;
		logic [15:0] factor;
		logic [31:0] deadline;
	} entry_t;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_PICK  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] STAT_UPDATED = 3'd0;
	localparam logic [2:0] STAT_ADDED   = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_PICKED  = 3'd3;
	localparam logic [2:0] STAT_EMPTY   = 3'd4;
	localparam logic [2:0] STAT_CLEARED = 3'd5;
	localparam logic [2:0] STAT_UNKNOWN = 3'd6;

	localparam logic [1:0] CFG_PREFERRED_HOST  = 2'd0;
	localparam logic [1:0] CFG_LOCAL_BONUS     = 2'd1;
	localparam logic [1:0] CFG_STALE_THRESHOLD = 2'd2;

	localparam logic [9:0]  LOCAL_BONUS_RESET     = 10'd307;
	localparam logic [8:0]  STALE_THRESHOLD_RESET = 9'd205;
	localparam logic [21:0] WEIGHT_MAX            = 22'h3FFFFF;
	localparam logic [31:0] UNITY_Q88             = 32'd256;
	localparam logic [31:0] PERCENT_SCALE         = 32'd25600;

endpackage

### design/weighted_random_server_picker.sv
// Weighted random server picker. Keeps an ordered table of up to TABLE_DEPTH server entries in
// one single-port-read memory plus a scratch memory of scaled weights, and serves one item at
// a time under a sequencer that shares a single 32x32 multiplier. An add walks the table for
// a matching key, a clear or unknown kind goes straight to its result, and a pick prunes
// expired entries, scales the weights, searches and removes the chosen entry; the walks are set
// by the one memory read per cycle and the shared multiplier. in_stall is high while an item
// is in work; a finished result waits in the output register, so the next item can be
// accepted while it is still stalled.
module weighted_random_server_picker
	import wrsp_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] entry_key,
	input  logic [31:0] entry_host,
	input  logic [15:0] entry_rate,
	input  logic [15:0] entry_coef,
	input  logic [15:0] entry_lifetime,
	input  logic [31:0] now,
	input  logic [15:0] random_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        refresh_needed,
	output logic [31:0] picked_key,
	output logic [31:0] picked_host,
	output logic [21:0] picked_weight
);

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int TW  = 16 + AW;
	localparam int TWW = 22 + AW;

	state_t state_q, state_nx;

	logic [31:0] pref_host_q;
	logic [9:0]  local_bonus_q;
	logic [8:0]  stale_thr_q;

	logic [31:0] key_q, host_q, now_q;
	logic [15:0] rate_q, coef_q, life_q, rv_q;

	logic [CW-1:0]  count_q, idx_q, wr_q;
	logic [TW-1:0]  total_q, live_q;
	logic [TWW-1:0] totw_q, cum_q;
	logic [21:0]    acc_q;
	logic           latched_q, neg_q;
	logic [AW-1:0]  latch_i_q, pick_q;
	logic [15:0]    p_q, cneg_q;
	logic [63:0]    prod_q, lhs_q;

	logic        res_valid_q;
	logic [2:0]  res_status_q;
	logic        res_refresh_q;
	logic [31:0] res_key_q, res_host_q;
	logic [21:0] res_weight_q;

	entry_t        mem [TABLE_DEPTH];
	logic [21:0]   wmem [TABLE_DEPTH];
	entry_t        rdata_q;
	logic [21:0]   wrd_q;

	logic          mem_we, wm_we, rd_en;
	logic [AW-1:0] mem_wa, rd_addr;
	entry_t        mem_wd, new_entry;
	logic [21:0]   wm_wd;
	logic [31:0]   mul_a, mul_b;

	logic          accept, out_free, key_match, is_local;
	logic [32:0]   dl_sum;
	logic [21:0]   scaled;
	logic [TWW-1:0] cum_nx;
	logic [63:0]   cum_scaled;
	logic [CW-1:0] idx_inc;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !res_valid_q || !out_stall;
	assign idx_inc   = CW'(idx_q + 1'b1);
	assign key_match = (rdata_q.key == key_q);
	assign is_local  = (rdata_q.host == pref_host_q);

	assign dl_sum = {1'b0, now_q} + {17'd0, life_q};
	always_comb begin
		new_entry.key      = key_q;
		new_entry.host     = host_q;
		new_entry.weight   = rate_q;
		new_entry.factor   = coef_q;
		new_entry.deadline = dl_sum[32] ? 32'hFFFFFFFF : dl_sum[31:0];
	end

	assign scaled     = (|prod_q[31:30]) ? WEIGHT_MAX : prod_q[29:8];
	assign cum_nx     = cum_q + TWW'(wrd_q);
	assign cum_scaled = (64'(cum_nx) << 16) - 64'(cum_nx);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_ADD:  state_nx = ST_ADD_RD;
						KIND_PICK: state_nx = ST_PR_RD;
						default:   state_nx = ST_DONE;
					endcase
				end
			end
			ST_ADD_RD:  state_nx = (idx_q == count_q) ? ST_DONE : ST_ADD_CHK;
			ST_ADD_CHK: state_nx = key_match ? ST_DONE : ST_ADD_RD;
			ST_PR_RD:   state_nx = (idx_q == count_q) ? ST_RF_MUL : ST_PR_CHK;
			ST_PR_CHK:  state_nx = ST_PR_RD;
			ST_RF_MUL:  state_nx = ST_RF_CHK;
			ST_RF_CHK:  state_nx = (count_q == '0) ? ST_DONE : ST_SC_RD;
			ST_SC_RD: begin
				if (idx_q == count_q) begin
					state_nx = latched_q ? ST_LT_M1 : ST_SR_MUL;
				end else begin
					state_nx = ST_SC_MUL;
				end
			end
			ST_SC_MUL:  state_nx = ST_SC_ACC;
			ST_SC_ACC:  state_nx = ST_SC_RD;
			ST_LT_M1:   state_nx = ST_LT_M2;
			ST_LT_M2:   state_nx = ST_LT_M3;
			ST_LT_M3:   state_nx = ST_LT_CHK;
			ST_LT_CHK:  state_nx = (lhs_q < prod_q) ? ST_SR_MUL : ST_OUT_RD;
			ST_SR_MUL:  state_nx = ST_SR_LHS;
			ST_SR_LHS:  state_nx = ST_SR_RD;
			ST_SR_RD:   state_nx = (idx_q == count_q) ? ST_OUT_RD : ST_SR_CHK;
			ST_SR_CHK:  state_nx = (lhs_q <= cum_scaled) ? ST_OUT_RD : ST_SR_RD;
			ST_OUT_RD:  state_nx = ST_OUT_CAP;
			ST_OUT_CAP: state_nx = ST_RM_RD;
			ST_RM_RD:   state_nx = (idx_inc >= count_q) ? ST_DONE : ST_RM_WR;
			ST_RM_WR:   state_nx = ST_RM_RD;
			ST_DONE:    state_nx = out_free ? ST_IDLE : ST_DONE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// Memory and multiplier controls.
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = idx_q[AW-1:0];
		mem_wd  = rdata_q;
		wm_we   = 1'b0;
		wm_wd   = scaled;
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_ADD_RD: begin
				if (idx_q == count_q) begin
					mem_we = (count_q != CW'(TABLE_DEPTH));
					mem_wa = count_q[AW-1:0];
					mem_wd = new_entry;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_ADD_CHK: begin
				mem_we = key_match;
				mem_wd = new_entry;
			end
			ST_PR_RD:  rd_en = (idx_q != count_q);
			ST_PR_CHK: begin
				mem_we = !(rdata_q.deadline < now_q);
				mem_wa = wr_q[AW-1:0];
			end
			ST_RF_MUL: begin
				mul_a = 32'(stale_thr_q);
				mul_b = 32'(total_q);
			end
			ST_SC_RD:  rd_en = (idx_q != count_q);
			ST_SC_MUL: begin
				mul_a = 32'(rdata_q.weight);
				if (!is_local) begin
					mul_b = UNITY_Q88;
				end else if (rdata_q.factor[15] || rdata_q.factor == '0) begin
					mul_b = 32'(local_bonus_q);
				end else begin
					mul_b = 32'(rdata_q.factor);
				end
			end
			ST_SC_ACC: wm_we = 1'b1;
			ST_LT_M1: begin
				mul_a = 32'(acc_q);
				mul_b = 32'(CW'(count_q - 1'b1));
			end
			ST_LT_M2: begin
				mul_a = prod_q[31:0];
				mul_b = PERCENT_SCALE;
			end
			ST_LT_M3: begin
				mul_a = 32'(p_q);
				mul_b = 32'(TWW'(totw_q - TWW'(acc_q)));
			end
			ST_SR_MUL: begin
				mul_a = 32'(totw_q);
				mul_b = 32'(rv_q);
			end
			ST_SR_RD:  rd_en = (idx_q != count_q);
			ST_OUT_RD: begin
				rd_en   = 1'b1;
				rd_addr = pick_q;
			end
			ST_RM_RD: begin
				rd_en   = (idx_inc < count_q);
				rd_addr = idx_inc[AW-1:0];
			end
			ST_RM_WR:  mem_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (wm_we) begin
			wmem[idx_q[AW-1:0]] <= wm_wd;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			wrd_q   <= wmem[rd_addr];
		end
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pref_host_q   <= '0;
			local_bonus_q <= LOCAL_BONUS_RESET;
			stale_thr_q   <= STALE_THRESHOLD_RESET;
			count_q       <= '0;
			res_valid_q   <= 1'b0;
			key_q         <= '0;
			host_q        <= '0;
			rate_q        <= '0;
			coef_q        <= '0;
			life_q        <= '0;
			now_q         <= '0;
			rv_q          <= '0;
			idx_q         <= '0;
			wr_q          <= '0;
			total_q       <= '0;
			live_q        <= '0;
			totw_q        <= '0;
			cum_q         <= '0;
			acc_q         <= '0;
			latched_q     <= 1'b0;
			neg_q         <= 1'b0;
			cneg_q        <= '0;
			latch_i_q     <= '0;
			pick_q        <= '0;
			p_q           <= '0;
			lhs_q         <= '0;
			res_status_q  <= '0;
			res_refresh_q <= 1'b0;
			res_key_q     <= '0;
			res_host_q    <= '0;
			res_weight_q  <= '0;
			status         <= '0;
			refresh_needed <= 1'b0;
			picked_key     <= '0;
			picked_host    <= '0;
			picked_weight  <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_PREFERRED_HOST:  pref_host_q   <= cfg_data;
					CFG_LOCAL_BONUS:     local_bonus_q <= cfg_data[9:0];
					CFG_STALE_THRESHOLD: stale_thr_q   <= cfg_data[8:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q         <= entry_key;
						host_q        <= entry_host;
						rate_q        <= entry_rate;
						coef_q        <= entry_coef;
						life_q        <= entry_lifetime;
						now_q         <= now;
						rv_q          <= random_value;
						idx_q         <= '0;
						wr_q          <= '0;
						total_q       <= '0;
						live_q        <= '0;
						res_refresh_q <= 1'b0;
						res_key_q     <= '0;
						res_host_q    <= '0;
						res_weight_q  <= '0;
						unique case (kind)
							KIND_ADD:   res_status_q <= STAT_UPDATED;
							KIND_PICK:  res_status_q <= STAT_PICKED;
							KIND_CLEAR: begin
								res_status_q <= STAT_CLEARED;
								count_q      <= '0;
							end
							default:    res_status_q <= STAT_UNKNOWN;
						endcase
					end
				end
				ST_ADD_RD: begin
					if (idx_q == count_q) begin
						if (count_q == CW'(TABLE_DEPTH)) begin
							res_status_q <= STAT_FULL;
						end else begin
							res_status_q <= STAT_ADDED;
							count_q      <= CW'(count_q + 1'b1);
						end
					end
				end
				ST_ADD_CHK: begin
					if (!key_match) begin
						idx_q <= idx_inc;
					end
				end
				ST_PR_RD: begin
					if (idx_q == count_q) begin
						count_q <= wr_q;
					end
				end
				ST_PR_CHK: begin
					total_q <= TW'(total_q + TW'(rdata_q.weight));
					if (!(rdata_q.deadline < now_q)) begin
						live_q <= TW'(live_q + TW'(rdata_q.weight));
						wr_q   <= CW'(wr_q + 1'b1);
					end
					idx_q <= idx_inc;
				end
				ST_RF_CHK: begin
					res_refresh_q <= (total_q == '0) || ((64'(live_q) << 8) < prod_q);
					if (count_q == '0) begin
						res_status_q <= STAT_EMPTY;
					end
					idx_q     <= '0;
					totw_q    <= '0;
					acc_q     <= '0;
					latched_q <= 1'b0;
				end
				ST_SC_MUL: begin
					neg_q  <= is_local && rdata_q.factor[15];
					cneg_q <= 16'(~rdata_q.factor + 1'b1);
				end
				ST_SC_ACC: begin
					totw_q <= TWW'(totw_q + TWW'(scaled));
					if (neg_q && acc_q < scaled) begin
						acc_q     <= scaled;
						latched_q <= 1'b1;
						latch_i_q <= idx_q[AW-1:0];
						p_q       <= cneg_q;
					end
					idx_q <= idx_inc;
				end
				ST_LT_M3: lhs_q <= prod_q;
				ST_LT_CHK: pick_q <= latch_i_q;
				ST_SR_LHS: begin
					lhs_q <= prod_q;
					idx_q <= '0;
					cum_q <= '0;
				end
				ST_SR_RD: begin
					if (idx_q == count_q) begin
						pick_q <= AW'(count_q - 1'b1);
					end
				end
				ST_SR_CHK: begin
					cum_q  <= cum_nx;
					pick_q <= idx_q[AW-1:0];
					idx_q  <= idx_inc;
				end
				ST_OUT_CAP: begin
					res_key_q    <= rdata_q.key;
					res_host_q   <= rdata_q.host;
					res_weight_q <= wrd_q;
					idx_q        <= CW'(pick_q);
				end
				ST_RM_RD: begin
					if (idx_inc >= count_q) begin
						count_q <= CW'(count_q - 1'b1);
					end
				end
				ST_RM_WR: idx_q <= idx_inc;
				ST_DONE: begin
					if (out_free) begin
						status         <= res_status_q;
						refresh_needed <= res_refresh_q;
						picked_key     <= res_key_q;
						picked_host    <= res_host_q;
						picked_weight  <= res_weight_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = res_valid_q;

endmodule

### test/weighted_random_server_picker_tb.sv
`timescale 1ns / 1ps

module weighted_random_server_picker_tb;
	import wrsp_pkg::*;

	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [2:0]  status;
		logic        refresh;
		logic [31:0] key;
		logic [31:0] host;
		logic [21:0] weight;
	} pick_result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write = 0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [31:0] entry_key = '0;
	logic [31:0] entry_host = '0;
	logic [15:0] entry_rate = 16'd1;
	logic [15:0] entry_coef = '0;
	logic [15:0] entry_lifetime = '0;
	logic [31:0] now = '0;
	logic [15:0] random_value = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic        refresh_needed;
	logic [31:0] picked_key;
	logic [31:0] picked_host;
	logic [21:0] picked_weight;

	// Shadow copy of the server table and registers.
	logic [31:0] tbl_key [DEPTH];
	logic [31:0] tbl_host [DEPTH];
	logic [15:0] tbl_rate [DEPTH];
	logic [15:0] tbl_coef [DEPTH];
	logic [31:0] tbl_deadline [DEPTH];
	int          tbl_count = 0;
	logic [31:0] pref_host = 32'd0;
	logic [9:0]  bonus = LOCAL_BONUS_RESET;
	logic [8:0]  threshold = STALE_THRESHOLD_RESET;

	pick_result_t expected_results[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  idle_enable = 1;
	bit  hold_receiver = 0;
	logic [31:0] time_now = 32'd1000;

	weighted_random_server_picker #(.TABLE_DEPTH(DEPTH)) u_top (.*);

	always #5 clk = ~clk;

	task automatic drop_entry(input int idx);
		for (int j = idx; j < tbl_count - 1; j++) begin
			tbl_key[j] = tbl_key[j + 1];
			tbl_host[j] = tbl_host[j + 1];
			tbl_rate[j] = tbl_rate[j + 1];
			tbl_coef[j] = tbl_coef[j + 1];
			tbl_deadline[j] = tbl_deadline[j + 1];
		end
		tbl_count--;
	endtask

	task automatic predict_result(input logic [1:0] k, input logic [31:0] key,
			input logic [31:0] host, input logic [15:0] rate, input logic [15:0] coef,
			input logic [15:0] life, input logic [31:0] tnow, input logic [15:0] rv);
		pick_result_t r;
		logic [63:0] total, live, total_w, access, p, lhs, dl, s;
		logic [63:0] cum [DEPTH];
		logic [63:0] w [DEPTH];
		bit latched;
		int idx, sel, latch_idx;
		r = '{default: '0};
		total = 0; live = 0; total_w = 0; access = 0; p = 0;
		latched = 0; latch_idx = 0;
		if (k == KIND_ADD) begin
			dl = 64'(tnow) + 64'(life);
			if (dl > 64'hFFFF_FFFF) dl = 64'hFFFF_FFFF;
			idx = tbl_count;
			for (int i = tbl_count - 1; i >= 0; i--)
				if (tbl_key[i] == key) idx = i;
			if (idx < tbl_count) begin
				r.status = STAT_UPDATED;
			end else if (tbl_count >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				r.status = STAT_ADDED;
				tbl_count++;
			end
			if (r.status != STAT_FULL) begin
				tbl_key[idx] = key;
				tbl_host[idx] = host;
				tbl_rate[idx] = rate;
				tbl_coef[idx] = coef;
				tbl_deadline[idx] = dl[31:0];
			end
		end else if (k == KIND_PICK) begin
			idx = 0;
			while (idx < tbl_count) begin
				total += tbl_rate[idx];
				if (tbl_deadline[idx] < tnow) begin
					drop_entry(idx);
				end else begin
					live += tbl_rate[idx];
					idx++;
				end
			end
			r.refresh = (total == 0) || (live * 256 < 64'(threshold) * total);
			if (tbl_count == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				for (int i = 0; i < tbl_count; i++) begin
					s = tbl_rate[i];
					if (tbl_host[i] == pref_host) begin
						if ($signed(tbl_coef[i]) <= 0) begin
							s = (s * bonus) >> 8;
							if (s > WEIGHT_MAX) s = WEIGHT_MAX;
							if ($signed(tbl_coef[i]) < 0 && access < s) begin
								access = s;
								latched = 1;
								latch_idx = i;
								p = 64'(-$signed(32'($signed(tbl_coef[i]))));
							end
						end else begin
							s = (s * tbl_coef[i]) >> 8;
							if (s > WEIGHT_MAX) s = WEIGHT_MAX;
						end
					end
					w[i] = s;
					total_w += s;
					cum[i] = total_w;
				end
				if (latched && access * 64'(tbl_count - 1) * 25600 < p * (total_w - access))
					latched = 0;
				if (latched) begin
					sel = latch_idx;
				end else begin
					lhs = total_w * rv;
					sel = tbl_count - 1;
					for (int i = tbl_count - 1; i >= 0; i--)
						if (lhs <= cum[i] * 65535) sel = i;
				end
				r.status = STAT_PICKED;
				r.key = tbl_key[sel];
				r.host = tbl_host[sel];
				r.weight = w[sel][21:0];
				drop_entry(sel);
			end
		end else if (k == KIND_CLEAR) begin
			tbl_count = 0;
			r.status = STAT_CLEARED;
		end else begin
			r.status = STAT_UNKNOWN;
		end
		expected_results.push_back(r);
	endtask

	task automatic send_item(input logic [1:0] k, input logic [31:0] key,
			input logic [31:0] host, input logic [15:0] rate, input logic [15:0] coef,
			input logic [15:0] life, input logic [31:0] tnow, input logic [15:0] rv);
		while (idle_enable && $urandom_range(99) < 6) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		entry_key <= key;
		entry_host <= host;
		entry_rate <= rate;
		entry_coef <= coef;
		entry_lifetime <= life;
		now <= tnow;
		random_value <= rv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_result(k, key, host, rate, coef, life, tnow, rv);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 0;
		case (idx)
			CFG_PREFERRED_HOST:  pref_host = value;
			CFG_LOCAL_BONUS:     bonus = value[9:0];
			CFG_STALE_THRESHOLD: threshold = value[8:0];
			default: ;
		endcase
	endtask

	task automatic add_random(input logic [31:0] key);
		logic [31:0] host;
		host = ($urandom_range(2) == 0) ? pref_host : $urandom();
		send_item(KIND_ADD, key, host, 16'($urandom_range(65535, 1)), 16'($urandom()),
			16'($urandom_range(40)), time_now, 16'($urandom()));
	endtask

	task automatic test_directed();
		send_item(KIND_PICK, 0, 0, 1, 0, 0, time_now, 0);
		send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF,
			16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF);
		send_item(KIND_ADD, 32'h0, 32'h0, 16'd1, 16'h8000, 16'd0, time_now, 0);
		send_item(KIND_ADD, 32'h0, 32'h0, 16'd300, 16'hFF00, 16'd5, time_now, 0);
		send_item(KIND_ADD, 32'd7, 32'h0, 16'd2, 16'h0100, 16'd5, time_now, 0);
		send_item(KIND_ADD, 32'd8, 32'h5, 16'd3, 16'h0, 16'd0, time_now, 0);
		send_item(2'd3, 1, 1, 1, 1, 1, 1, 1);
		send_item(KIND_PICK, 0, 0, 1, 0, 0, time_now + 3, 16'hFFFF);
		send_item(KIND_PICK, 0, 0, 1, 0, 0, time_now, 16'h0000);
		send_item(KIND_PICK, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 16'h8000);
		send_item(KIND_CLEAR, 0, 0, 1, 0, 0, time_now, 0);
		for (int i = 0; i < DEPTH + 2; i++)
			send_item(KIND_ADD, i, i[0] ? pref_host : 32'd9, 16'(i * 97 + 1), 16'h0,
				16'd100, time_now, 0);
		send_item(KIND_PICK, 0, 0, 1, 0, 0, time_now, 16'd12345);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			time_now = time_now + $urandom_range(6);
			case ($urandom_range(9))
				0, 1, 2, 3, 4: add_random($urandom_range(23));
				5, 6, 7: send_item(KIND_PICK, $urandom(), $urandom(), 16'($urandom()),
					16'($urandom()), 16'($urandom()), time_now, 16'($urandom()));
				8: send_item(KIND_CLEAR, $urandom(), $urandom(), 16'($urandom()),
					16'($urandom()), 16'($urandom()), time_now, 16'($urandom()));
				default: send_item(2'($urandom_range(3)), $urandom(), $urandom(),
					16'($urandom()), 16'($urandom()), 16'($urandom()), time_now,
					16'($urandom()));
			endcase
			sent++;
		end
	endtask

	task automatic test_register_settings();
		write_register(CFG_PREFERRED_HOST, 32'hFFFF_FFFF);
		write_register(CFG_LOCAL_BONUS, 32'd1023);
		write_register(CFG_STALE_THRESHOLD, 32'd256);
		test_random_traffic(80);
		wait_drained();
		write_register(CFG_PREFERRED_HOST, $urandom());
		write_register(CFG_LOCAL_BONUS, 32'd256);
		write_register(CFG_STALE_THRESHOLD, 32'd0);
		test_random_traffic(80);
		wait_drained();
		write_register(CFG_PREFERRED_HOST, 32'd0);
		write_register(CFG_LOCAL_BONUS, $urandom_range(1023, 256));
		write_register(CFG_STALE_THRESHOLD, $urandom_range(256));
	endtask

	task automatic test_backpressure();
		hold_receiver = 1;
		for (int i = 0; i < 6; i++) add_random($urandom_range(23));
		hold_receiver = 0;
		wait_drained();
	endtask

	task automatic test_no_idle();
		idle_enable = 0;
		test_random_traffic(60);
		idle_enable = 1;
	endtask

	// Receiver side: random stalls, plus a held stall on request, bounded by HOLD_CYCLES.
	always @(posedge clk) begin
		if (hold_receiver && idle_cycles < HOLD_CYCLES) begin
			out_stall <= 1;
			idle_cycles <= idle_cycles + 1;
		end else begin
			out_stall <= idle_enable && ($urandom_range(99) < 6);
			if (!hold_receiver) idle_cycles <= 0;
		end
	end

	always @(posedge clk) begin
		pick_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected, status %0d", status);
				error_count++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					error_count++;
				end
				if (refresh_needed !== e.refresh) begin
					$error("refresh_needed expected %0d actual %0d", e.refresh, refresh_needed);
					error_count++;
				end
				if (picked_key !== e.key) begin
					$error("picked_key expected %h actual %h", e.key, picked_key);
					error_count++;
				end
				if (picked_host !== e.host) begin
					$error("picked_host expected %h actual %h", e.host, picked_host);
					error_count++;
				end
				if (picked_weight !== e.weight) begin
					$error("picked_weight expected %h actual %h", e.weight, picked_weight);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles without any transfer.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_register_settings();
		test_backpressure();
		test_no_idle();
		test_random_traffic(180);
		wait_drained();
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
